[src/emc_pkg.sv]
// ----------------------------------------------------------------------------
// emc_pkg - constants for the epoch-ms to calendar converter
// Reciprocal multipliers for the constant divides, the range limit and the
// cumulative days-before-month table.
// ----------------------------------------------------------------------------
package emc_pkg;

    localparam int IN_W   = 42;
    localparam int DATA_W = 48;

    // last representable instant: 2099-12-31 23:59:59.999
    localparam logic [IN_W-1:0] LAST_MS = 42'd4102444799999;

    // ms per day = 2^10 * 84375
    localparam logic [16:0] DAY_ODD   = 17'd84375;
    // ceil(2^48 / 84375), exact for the in-range quotient
    localparam logic [31:0] M_DAY     = 32'd3335999724;
    // ceil(2^32 / 1461) + 1
    localparam logic [21:0] M_BLK     = 22'd2939746;
    localparam logic [10:0] BLK_DAYS  = 11'd1461;
    // ceil(2^32 / 125)
    localparam logic [25:0] M_125     = 26'd34359739;
    localparam logic [6:0]  C_125     = 7'd125;
    // ceil(2^20 / 15)
    localparam logic [16:0] M_15      = 17'd69906;
    // ceil(2^16 / 60)
    localparam logic [10:0] M_60      = 11'd1093;
    localparam logic [5:0]  C_60      = 6'd60;

    localparam logic [11:0] BASE_YEAR = 12'd1970;

    // year boundaries inside a four-year block that starts on a year = 2 mod 4
    localparam logic [10:0] YB1 = 11'd365;
    localparam logic [10:0] YB2 = 11'd730;
    localparam logic [10:0] YB3 = 11'd1096;

    typedef logic [8:0] t_doy;

    // days before the first of month idx (0 = January)
    function automatic t_doy days_before(input logic leap, input logic [3:0] idx);
        t_doy base;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && idx >= 4'd2 && idx <= 4'd11) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

[src/epoch_ms_to_calendar.sv]
// ----------------------------------------------------------------------------
// epoch_ms_to_calendar - millisecond timestamp to calendar date and time
// Six-stage pipeline: constant divides by reciprocal multiplication, then
// four-year block placement and a month table search.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                  | payload
//  s side  | in  | i_s_tvalid / o_s_tready    | i_s_tdata: epoch_ms
//  m side  | out | o_m_tvalid / i_m_tready    | o_m_tdata: date/time, o_m_tuser: out_of_range
//
//  One beat per cycle sustained while the m side does not stall.
//  The six stage registers set the latency; each stage holds one or two
//  constant multiplies.
//  Reset (synchronous, active low) clears only the stage valid bits.
//  Each stage takes a new beat when it is empty or its successor advances,
//  so a stall on the m side fills bubbles first and drops or repeats nothing.
// ----------------------------------------------------------------------------
module epoch_ms_to_calendar (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // [41:0] epoch_ms, [47:42] zero
    input  logic [emc_pkg::DATA_W-1:0] i_s_tdata,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // [11:0] year, [15:12] month, [20:16] day_of_month, [25:21] hour,
    // [31:26] minute, [37:32] second, [47:38] millisecond
    output logic [emc_pkg::DATA_W-1:0] o_m_tdata,
    // [0] out_of_range
    output logic [0:0]                 o_m_tuser
);
    import emc_pkg::*;

    localparam int NSTG = 6;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_adv;

    // stage advance chain, from the output backward
    always_comb begin
        n_adv[NSTG-1] = !r_vld[NSTG-1] || i_m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            n_adv[k] = !r_vld[k] || n_adv[k+1];
        end
    end

    assign o_s_tready = n_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_adv[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (n_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- stage 1: range check, day count ----------------
    // days = floor(ms / 2^10 / 84375)
    logic [63:0] n_s1_prod;
    logic        r1_oor;
    logic [15:0] r1_days;
    logic [16:0] r1_xlo;
    logic [9:0]  r1_lo10;

    assign n_s1_prod = {32'd0, i_s_tdata[41:10]} * {32'd0, M_DAY};

    always_ff @(posedge i_clk) begin
        if (n_adv[0]) begin
            r1_oor  <= i_s_tdata[IN_W-1:0] > LAST_MS;
            r1_days <= n_s1_prod[63:48];
            r1_xlo  <= i_s_tdata[26:10];
            r1_lo10 <= i_s_tdata[9:0];
        end
    end

    // ---------------- stage 2: ms of day, four-year block ----------------
    logic [32:0] n_s2_dm;
    logic [16:0] n_s2_rem;
    logic [37:0] n_s2_bp;
    logic        r2_oor;
    logic [26:0] r2_msd;
    logic [15:0] r2_days;
    logic [5:0]  r2_blk;

    assign n_s2_dm  = {17'd0, r1_days} * {16'd0, DAY_ODD};
    assign n_s2_rem = r1_xlo - n_s2_dm[16:0];
    assign n_s2_bp  = {22'd0, r1_days} * {16'd0, M_BLK};

    always_ff @(posedge i_clk) begin
        if (n_adv[1]) begin
            r2_oor  <= r1_oor;
            r2_msd  <= {n_s2_rem, r1_lo10};
            r2_days <= r1_days;
            r2_blk  <= n_s2_bp[37:32];
        end
    end

    // ---------------- stage 3: seconds of day, day in block ----------------
    logic [23:0] n_s3_y;
    logic [49:0] n_s3_sp;
    logic [16:0] n_s3_bd;
    logic        r3_oor;
    logic [16:0] r3_sod;
    logic [6:0]  r3_y7;
    logic [2:0]  r3_lo3;
    logic [5:0]  r3_blk;
    logic [10:0] r3_remb;

    assign n_s3_y  = r2_msd[26:3];
    assign n_s3_sp = {26'd0, n_s3_y} * {24'd0, M_125};
    assign n_s3_bd = {11'd0, r2_blk} * {6'd0, BLK_DAYS};

    always_ff @(posedge i_clk) begin
        if (n_adv[2]) begin
            r3_oor  <= r2_oor;
            r3_sod  <= n_s3_sp[48:32];
            r3_y7   <= n_s3_y[6:0];
            r3_lo3  <= r2_msd[2:0];
            r3_blk  <= r2_blk;
            r3_remb <= r2_days[10:0] - n_s3_bd[10:0];
        end
    end

    // ---------------- stage 4: ms, minute of day, year ----------------
    logic [23:0] n_s4_s125;
    logic [31:0] n_s4_mp;
    logic [1:0]  n_s4_yoff;
    logic [10:0] n_s4_base;
    logic [10:0] n_s4_doy;
    logic        r4_oor;
    logic [9:0]  r4_milli;
    logic [10:0] r4_mod;
    logic [5:0]  r4_sod6;
    logic [11:0] r4_year;
    logic        r4_leap;
    logic [8:0]  r4_doy0;

    assign n_s4_s125 = {7'd0, r3_sod} * {17'd0, C_125};
    assign n_s4_mp   = {17'd0, r3_sod[16:2]} * {15'd0, M_15};

    // block years run 365, 365, 366, 365 days
    always_comb begin
        if (r3_remb < YB1) begin
            n_s4_yoff = 2'd0;
            n_s4_base = 11'd0;
        end else if (r3_remb < YB2) begin
            n_s4_yoff = 2'd1;
            n_s4_base = YB1;
        end else if (r3_remb < YB3) begin
            n_s4_yoff = 2'd2;
            n_s4_base = YB2;
        end else begin
            n_s4_yoff = 2'd3;
            n_s4_base = YB3;
        end
    end

    assign n_s4_doy = r3_remb - n_s4_base;

    always_ff @(posedge i_clk) begin
        if (n_adv[3]) begin
            r4_oor   <= r3_oor;
            r4_milli <= {r3_y7 - n_s4_s125[6:0], r3_lo3};
            r4_mod   <= n_s4_mp[30:20];
            r4_sod6  <= r3_sod[5:0];
            r4_year  <= BASE_YEAR + {4'd0, r3_blk, 2'b00} + {10'd0, n_s4_yoff};
            r4_leap  <= n_s4_yoff == 2'd2;
            r4_doy0  <= n_s4_doy[8:0];
        end
    end

    // ---------------- stage 5: hour, second, month, day ----------------
    logic [16:0] n_s5_m60;
    logic [21:0] n_s5_hp;
    logic [3:0]  n_s5_mon;
    t_doy        n_s5_before;
    t_doy        n_s5_day;
    logic        r5_oor;
    logic [9:0]  r5_milli;
    logic [5:0]  r5_second;
    logic [4:0]  r5_hour;
    logic [5:0]  r5_mod6;
    logic [11:0] r5_year;
    logic [3:0]  r5_month;
    logic [4:0]  r5_day;

    assign n_s5_m60 = {6'd0, r4_mod} * {11'd0, C_60};
    assign n_s5_hp  = {11'd0, r4_mod} * {11'd0, M_60};

    // last month whose start lies at or before the day of year
    always_comb begin
        n_s5_mon    = 4'd0;
        n_s5_before = '0;
        for (int m = 0; m < 12; m++) begin
            if (days_before(r4_leap, 4'(m)) <= r4_doy0) begin
                n_s5_mon    = 4'(m);
                n_s5_before = days_before(r4_leap, 4'(m));
            end
        end
        n_s5_day = r4_doy0 - n_s5_before + 9'd1;
    end

    always_ff @(posedge i_clk) begin
        if (n_adv[4]) begin
            r5_oor    <= r4_oor;
            r5_milli  <= r4_milli;
            r5_second <= r4_sod6 - n_s5_m60[5:0];
            r5_hour   <= n_s5_hp[20:16];
            r5_mod6   <= r4_mod[5:0];
            r5_year   <= r4_year;
            r5_month  <= n_s5_mon + 4'd1;
            r5_day    <= n_s5_day[4:0];
        end
    end

    // ---------------- stage 6: minute, zeroing, output register ----------------
    logic [10:0]       n_s6_h60;
    logic [5:0]        n_s6_minute;
    logic [DATA_W-1:0] r6_tdata;
    logic              r6_oor;

    assign n_s6_h60    = {6'd0, r5_hour} * {5'd0, C_60};
    assign n_s6_minute = r5_mod6 - n_s6_h60[5:0];

    always_ff @(posedge i_clk) begin
        if (n_adv[5]) begin
            r6_oor <= r5_oor;
            if (r5_oor) begin
                r6_tdata <= '0;
            end else begin
                r6_tdata <= {r5_milli, r5_second, n_s6_minute, r5_hour,
                             r5_day, r5_month, r5_year};
            end
        end
    end

    assign o_m_tvalid   = r_vld[NSTG-1];
    assign o_m_tdata    = r6_tdata;
    assign o_m_tuser[0] = r6_oor;

    // ---------------- assertions ----------------
    // an empty or draining output always lets the input side move
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid || i_m_tready) |-> o_s_tready)
        else $error("input stalled while output can drain");

    // out-of-range beats carry an all-zero date
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("out-of-range beat with nonzero fields");

    // in-range beats carry a legal month and hour and a day of at least 1
    a_date_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |->
            (o_m_tdata[15:12] >= 4'd1 && o_m_tdata[15:12] <= 4'd12 &&
             o_m_tdata[20:16] >= 5'd1 && o_m_tdata[25:21] <= 5'd23))
        else $error("illegal month, day or hour");

endmodule
